>>> hw/rtl/bprf_pkg.sv
// Package for the BOOTP reply frame filter: frame offsets, reason codes and field widths.
package bprf_pkg;

    // Frame byte offsets, counted from the Ethernet destination address
    localparam int unsigned SRC_FIRST  = 6;
    localparam int unsigned SRC_LAST   = 11;
    localparam int unsigned IP_FIRST   = 14;
    localparam int unsigned IP_LAST    = 33;
    localparam int unsigned PROTO_POS  = 23;
    localparam int unsigned SUM_HI     = 24;
    localparam int unsigned SUM_LO     = 25;
    localparam int unsigned PORT_FIRST = 34;
    localparam int unsigned PORT_LAST  = 37;
    localparam int unsigned OP_POS     = 42;
    localparam int unsigned YI_FIRST   = 58;
    localparam int unsigned YI_LAST    = 61;
    localparam int unsigned SI_FIRST   = 62;
    localparam int unsigned SI_LAST    = 65;
    localparam int unsigned CH_FIRST   = 70;
    localparam int unsigned CH_LAST    = 75;
    localparam int unsigned MIN_LEN    = 86;

    // Expected header values
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] PORT_SERVER = 16'd67;
    localparam logic [15:0] PORT_CLIENT = 16'd68;
    localparam logic [7:0]  OP_REPLY    = 8'd2;

    // Field widths
    localparam int unsigned MAC_W   = 48;
    localparam int unsigned IP_W    = 32;
    localparam int unsigned HSUM_W  = 20;
    localparam int unsigned OUT_W   = 120;

    // Frame verdict, first failing check wins
    typedef enum logic [2:0] {
        RSN_OK        = 3'd0,
        RSN_CHECKSUM  = 3'd1,
        RSN_NOT_UDP   = 3'd2,
        RSN_PORTS     = 3'd3,
        RSN_NOT_REPLY = 3'd4,
        RSN_MAC       = 3'd5,
        RSN_SHORT     = 3'd6
    } t_reason;

endpackage

>>> hw/rtl/bootp_reply_frame_filter.sv
// BOOTP reply frame filter: checks one received frame a byte at a time and reports a verdict.
//
// The block takes one frame byte per clock cycle, with no gaps needed between frames. Each
// byte goes into an input register and is folded into the per-frame state (IPv4 header
// one's-complement sum, protocol, UDP ports, BOOTP op, chaddr match, yiaddr, siaddr, source
// MAC) in the next cycle; the result for a frame is written to the output register when
// its final byte leaves the input register. The header checksum, the chaddr compare and the
// field captures each touch one byte per cycle, which sets the rate at one byte per cycle.
// Input is held off only when a final byte reaches the judging stage while the previous
// result still waits in the output register. Frames are judged on their first 86 bytes;
// shorter frames are reported as short.
module bootp_reply_frame_filter #(
    parameter int unsigned FRAME_BYTES_MAX = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: own_mac
    input  logic                         i_cfg_wr_en,
    input  logic [bprf_pkg::MAC_W-1:0]   i_cfg_wr_data,
    // input stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,  // [7:0] frame_byte
    input  logic                         i_s_axis_tlast,  // last_byte
    // result stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [0] accepted, [3:1] reject_reason, [35:4] assigned_ip, [67:36] siaddr,
    // [115:68] source MAC, [119:116] zero
    output logic [bprf_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    localparam int unsigned POS_W = $clog2(FRAME_BYTES_MAX);
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(FRAME_BYTES_MAX - 1);

    // configuration register
    logic [bprf_pkg::MAC_W-1:0] r_own_mac;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // per-frame state
    logic [POS_W-1:0]            r_pos,      n_pos;
    logic [bprf_pkg::HSUM_W-1:0] r_hsum,     n_hsum;
    logic [7:0]                  r_hold,     n_hold;
    logic [15:0]                 r_rx_sum,   n_rx_sum;
    logic [7:0]                  r_proto,    n_proto;
    logic [31:0]                 r_ports,    n_ports;
    logic [7:0]                  r_op,       n_op;
    logic                        r_ch_match, n_ch_match;
    logic [bprf_pkg::IP_W-1:0]   r_yiaddr,   n_yiaddr;
    logic [bprf_pkg::IP_W-1:0]   r_siaddr,   n_siaddr;
    logic [bprf_pkg::MAC_W-1:0]  r_src_mac,  n_src_mac;

    // output register
    logic                        r_out_valid;
    logic                        r_out_accepted;
    bprf_pkg::t_reason           r_out_reason;
    logic [bprf_pkg::IP_W-1:0]   r_out_yiaddr;
    logic [bprf_pkg::IP_W-1:0]   r_out_siaddr;
    logic [bprf_pkg::MAC_W-1:0]  r_out_mac;

    logic              advance;
    logic              in_ip;
    logic [7:0]        word_byte;
    logic [7:0]        want_byte;
    logic              in_ch;
    logic [16:0]       fold1;
    logic [15:0]       fold2;
    logic [15:0]       calc_sum;
    bprf_pkg::t_reason reason;

    // handshake: the judging stage moves unless a verdict would overwrite a waiting result
    assign advance         = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_mac, r_out_siaddr, r_out_yiaddr,
                              r_out_reason, r_out_accepted};

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
        end else if (i_cfg_wr_en) begin
            r_own_mac <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // own_mac byte expected at the current chaddr position, first byte most significant
    always_comb begin
        want_byte = '0;
        in_ch     = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (r_pos == POS_W'(bprf_pkg::CH_FIRST + i)) begin
                want_byte = r_own_mac[8*(5-i) +: 8];
                in_ch     = 1'b1;
            end
        end
    end

    // per-byte capture and header sum
    always_comb begin
        n_pos      = r_pos;
        n_hsum     = r_hsum;
        n_hold     = r_hold;
        n_rx_sum   = r_rx_sum;
        n_proto    = r_proto;
        n_ports    = r_ports;
        n_op       = r_op;
        n_ch_match = r_ch_match;
        n_yiaddr   = r_yiaddr;
        n_siaddr   = r_siaddr;
        n_src_mac  = r_src_mac;

        in_ip     = (r_pos >= POS_W'(bprf_pkg::IP_FIRST)) && (r_pos <= POS_W'(bprf_pkg::IP_LAST));
        word_byte = r_in_byte;

        if (in_ip) begin
            // checksum field counts as zero in the sum
            if (r_pos == POS_W'(bprf_pkg::SUM_HI) || r_pos == POS_W'(bprf_pkg::SUM_LO)) begin
                n_rx_sum  = {r_rx_sum[7:0], r_in_byte};
                word_byte = '0;
            end
            // header starts on an even offset: even bytes are the high half of a word
            if (!r_pos[0]) begin
                n_hold = word_byte;
            end else begin
                n_hsum = r_hsum + bprf_pkg::HSUM_W'({r_hold, word_byte});
            end
        end
        if (r_pos == POS_W'(bprf_pkg::PROTO_POS)) begin
            n_proto = r_in_byte;
        end
        if (r_pos >= POS_W'(bprf_pkg::PORT_FIRST) && r_pos <= POS_W'(bprf_pkg::PORT_LAST)) begin
            n_ports = {r_ports[23:0], r_in_byte};
        end
        if (r_pos == POS_W'(bprf_pkg::OP_POS)) begin
            n_op = r_in_byte;
        end
        if (r_pos >= POS_W'(bprf_pkg::YI_FIRST) && r_pos <= POS_W'(bprf_pkg::YI_LAST)) begin
            n_yiaddr = {r_yiaddr[23:0], r_in_byte};
        end
        if (r_pos >= POS_W'(bprf_pkg::SI_FIRST) && r_pos <= POS_W'(bprf_pkg::SI_LAST)) begin
            n_siaddr = {r_siaddr[23:0], r_in_byte};
        end
        if (r_pos >= POS_W'(bprf_pkg::SRC_FIRST) && r_pos <= POS_W'(bprf_pkg::SRC_LAST)) begin
            n_src_mac = {r_src_mac[bprf_pkg::MAC_W-9:0], r_in_byte};
        end
        if (in_ch && (want_byte != r_in_byte)) begin
            n_ch_match = 1'b0;
        end

        if (r_pos < POS_SAT) begin
            n_pos = r_pos + POS_W'(1);
        end

        // final byte: start the next frame from clean state
        if (r_in_last) begin
            n_pos      = '0;
            n_hsum     = '0;
            n_hold     = '0;
            n_rx_sum   = '0;
            n_proto    = '0;
            n_ports    = '0;
            n_op       = '0;
            n_ch_match = 1'b1;
            n_yiaddr   = '0;
            n_siaddr   = '0;
            n_src_mac  = '0;
        end
    end

    // verdict; any byte from offset 85 on changes no captured field, so the registered
    // state is complete whenever the frame is long enough to be judged
    always_comb begin
        fold1    = {13'd0, r_hsum[19:16]} + {1'b0, r_hsum[15:0]};
        fold2    = fold1[15:0] + {15'd0, fold1[16]};
        calc_sum = ~fold2;

        if (r_pos < POS_W'(bprf_pkg::MIN_LEN - 1)) begin
            reason = bprf_pkg::RSN_SHORT;
        end else if (calc_sum != r_rx_sum) begin
            reason = bprf_pkg::RSN_CHECKSUM;
        end else if (r_proto != bprf_pkg::PROTO_UDP) begin
            reason = bprf_pkg::RSN_NOT_UDP;
        end else if (r_ports[15:0] != bprf_pkg::PORT_CLIENT ||
                     r_ports[31:16] != bprf_pkg::PORT_SERVER) begin
            reason = bprf_pkg::RSN_PORTS;
        end else if (r_op != bprf_pkg::OP_REPLY) begin
            reason = bprf_pkg::RSN_NOT_REPLY;
        end else if (!r_ch_match) begin
            reason = bprf_pkg::RSN_MAC;
        end else begin
            reason = bprf_pkg::RSN_OK;
        end
    end

    // per-frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hsum     <= '0;
            r_hold     <= '0;
            r_rx_sum   <= '0;
            r_proto    <= '0;
            r_ports    <= '0;
            r_op       <= '0;
            r_ch_match <= 1'b1;
            r_yiaddr   <= '0;
            r_siaddr   <= '0;
            r_src_mac  <= '0;
        end else if (advance) begin
            r_pos      <= n_pos;
            r_hsum     <= n_hsum;
            r_hold     <= n_hold;
            r_rx_sum   <= n_rx_sum;
            r_proto    <= n_proto;
            r_ports    <= n_ports;
            r_op       <= n_op;
            r_ch_match <= n_ch_match;
            r_yiaddr   <= n_yiaddr;
            r_siaddr   <= n_siaddr;
            r_src_mac  <= n_src_mac;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_accepted <= (reason == bprf_pkg::RSN_OK);
            r_out_reason   <= reason;
            r_out_yiaddr   <= (reason == bprf_pkg::RSN_OK) ? r_yiaddr  : '0;
            r_out_siaddr   <= (reason == bprf_pkg::RSN_OK) ? r_siaddr  : '0;
            r_out_mac      <= (reason == bprf_pkg::RSN_OK) ? r_src_mac : '0;
        end
    end

    // input is held off only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_in_last && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without a pending verdict");

    // a final byte restarts the position count
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_pos == '0) && r_ch_match)
        else $error("frame state not cleared after final byte");

    // position never runs past saturation
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("byte position past saturation");

    // accept flag agrees with reason, and rejected results carry no addresses
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_accepted == (r_out_reason == bprf_pkg::RSN_OK)) &&
                         (r_out_accepted || (r_out_yiaddr == '0 && r_out_siaddr == '0 &&
                                             r_out_mac == '0))))
        else $error("inconsistent verdict fields");

    // a result waiting for the sink is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> r_out_valid && $stable(r_out_reason))
        else $error("pending verdict lost");

endmodule

>>> test/testbench.sv
// Testbench for the BOOTP reply frame filter: random and directed frames checked against a predictor.
module testbench;
    import bprf_pkg::*;

    // any limit from 86 up gives the same verdicts; a small one lets a frame of modest length saturate
    localparam int unsigned FRAME_MAX   = 128;
    localparam int unsigned STALL_LIMIT = 2000;

    // Kinds of damage applied to a generated frame
    typedef enum int {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_PROTO,
        FLAW_SRC_PORT,
        FLAW_DST_PORT,
        FLAW_OP,
        FLAW_MAC,
        FLAW_NOISE
    } t_flaw;

    // Background content of a generated frame
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONE
    } t_fill;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct {
        logic        accepted;
        t_reason     reason;
        logic [31:0] yiaddr;
        logic [31:0] siaddr;
        logic [47:0] smac;
    } t_verdict;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_wr_en     = 1'b0;
    logic [MAC_W-1:0]   i_cfg_wr_data   = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata  = '0;  // [7:0] frame_byte
    logic               i_s_axis_tlast  = 1'b0;  // last_byte
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    // [0] accepted, [3:1] reject_reason, [35:4] assigned_ip, [67:36] siaddr,
    // [115:68] source MAC, [119:116] zero
    logic [OUT_W-1:0]   o_m_axis_tdata;

    t_beat    tx_bytes[$];
    t_verdict verdict_q[$];
    int       mismatches  = 0;
    int       idle_cycles = 0;

    // Predictor copy of the per-frame state and of own_mac
    logic [47:0] own_mac_copy = '0;
    logic [10:0] pos;
    logic [19:0] hdr_sum;
    logic [7:0]  hi_hold;
    logic [15:0] rx_sum;
    logic [7:0]  proto;
    logic [31:0] port_pair;
    logic [7:0]  op;
    logic        chaddr_ok;
    logic [31:0] yiaddr;
    logic [31:0] siaddr;
    logic [47:0] src_mac;

    bootp_reply_frame_filter #(
        .FRAME_BYTES_MAX(FRAME_MAX)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic restart_frame();
        pos       = '0;
        hdr_sum   = '0;
        hi_hold   = '0;
        rx_sum    = '0;
        proto     = '0;
        port_pair = '0;
        op        = '0;
        chaddr_ok = 1'b1;
        yiaddr    = '0;
        siaddr    = '0;
        src_mac   = '0;
    endtask

    // Fold one accepted byte into the predicted state; push a verdict on the final byte
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int unsigned p;
        logic [7:0]  word_lo;
        logic [16:0] fold;
        logic [15:0] calc;
        t_reason     rsn;
        t_verdict    v;
        p = pos;
        if (p >= IP_FIRST && p <= IP_LAST) begin
            word_lo = b;
            // checksum field is captured but summed as zero
            if (p == SUM_HI || p == SUM_LO) begin
                rx_sum  = {rx_sum[7:0], b};
                word_lo = 8'h00;
            end
            if (((p - IP_FIRST) & 1) == 0)
                hi_hold = word_lo;
            else
                hdr_sum = hdr_sum + {hi_hold, word_lo};
        end
        if (p == PROTO_POS)
            proto = b;
        if (p >= PORT_FIRST && p <= PORT_LAST)
            port_pair = {port_pair[23:0], b};
        if (p == OP_POS)
            op = b;
        if (p >= YI_FIRST && p <= YI_LAST)
            yiaddr = {yiaddr[23:0], b};
        if (p >= SI_FIRST && p <= SI_LAST)
            siaddr = {siaddr[23:0], b};
        if (p >= SRC_FIRST && p <= SRC_LAST)
            src_mac = {src_mac[39:0], b};
        if (p >= CH_FIRST && p <= CH_LAST) begin
            if (own_mac_copy[8*(CH_LAST-p) +: 8] != b)
                chaddr_ok = 1'b0;
        end
        if (!last) begin
            if (pos < FRAME_MAX - 1)
                pos = pos + 1'b1;
        end else begin
            fold = hdr_sum[19:16] + hdr_sum[15:0];
            fold = fold + fold[16];
            calc = ~fold[15:0];
            if (p + 1 < MIN_LEN)
                rsn = RSN_SHORT;
            else if (calc != rx_sum)
                rsn = RSN_CHECKSUM;
            else if (proto != PROTO_UDP)
                rsn = RSN_NOT_UDP;
            else if (port_pair[15:0] != PORT_CLIENT || port_pair[31:16] != PORT_SERVER)
                rsn = RSN_PORTS;
            else if (op != OP_REPLY)
                rsn = RSN_NOT_REPLY;
            else if (!chaddr_ok)
                rsn = RSN_MAC;
            else
                rsn = RSN_OK;
            v.accepted = (rsn == RSN_OK);
            v.reason   = rsn;
            v.yiaddr   = (rsn == RSN_OK) ? yiaddr : '0;
            v.siaddr   = (rsn == RSN_OK) ? siaddr : '0;
            v.smac     = (rsn == RSN_OK) ? src_mac : '0;
            verdict_q.push_back(v);
            restart_frame();
        end
    endtask

    // Build one frame around the BOOTP reply layout, damage it, and queue its first len bytes
    task automatic queue_frame(input int len, input t_flaw flaw, input t_fill fill);
        logic [7:0]  f[];
        logic [19:0] sum;
        logic [16:0] fold;
        int          span;
        int          idx;
        span = (len > MIN_LEN) ? len : MIN_LEN;
        f = new[span];
        foreach (f[i]) begin
            case (fill)
                FILL_ZERO: f[i] = 8'h00;
                FILL_ONE:  f[i] = 8'hff;
                default:   f[i] = 8'($urandom_range(0, 255));
            endcase
        end
        if (flaw != FLAW_NOISE) begin
            f[12]        = 8'h08;
            f[13]        = 8'h00;
            f[IP_FIRST]  = 8'h45;
            f[PROTO_POS] = PROTO_UDP;
            {f[PORT_FIRST], f[PORT_FIRST+1]} = PORT_SERVER;
            {f[PORT_FIRST+2], f[PORT_LAST]}  = PORT_CLIENT;
            f[OP_POS]    = OP_REPLY;
            for (int k = 0; k < 6; k++)
                f[CH_FIRST+k] = own_mac_copy[47-8*k -: 8];
            case (flaw)
                FLAW_PROTO:
                    f[PROTO_POS] = PROTO_UDP ^ 8'($urandom_range(1, 255));
                FLAW_SRC_PORT:
                    {f[PORT_FIRST], f[PORT_FIRST+1]} = PORT_SERVER ^ 16'($urandom_range(1, 65535));
                FLAW_DST_PORT:
                    {f[PORT_FIRST+2], f[PORT_LAST]} = PORT_CLIENT ^ 16'($urandom_range(1, 65535));
                FLAW_OP:
                    f[OP_POS] = OP_REPLY ^ 8'($urandom_range(1, 255));
                FLAW_MAC: begin
                    idx    = CH_FIRST + $urandom_range(0, 5);
                    f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
                end
                default: ;
            endcase
            // fill in a correct header checksum
            sum = '0;
            for (int i = IP_FIRST; i <= IP_LAST; i += 2) begin
                if (i != SUM_HI)
                    sum = sum + {f[i], f[i+1]};
            end
            fold = sum[19:16] + sum[15:0];
            fold = fold + fold[16];
            {f[SUM_HI], f[SUM_LO]} = ~fold[15:0];
            if (flaw == FLAW_CHECKSUM) begin
                idx    = IP_FIRST + $urandom_range(0, 19);
                f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
            end
        end
        for (int i = 0; i < len; i++)
            tx_bytes.push_back('{data: f[i], last: (i == len - 1)});
    endtask

    // Random traffic: mostly well-formed replies, plus damaged, short and noise frames
    task automatic random_traffic(input int target_bytes, input bit with_long);
        int    sent;
        int    pick;
        int    len;
        t_flaw flaw;
        sent = 0;
        // one long frame drives the byte counter into saturation
        if (with_long)
            queue_frame(FRAME_MAX + 2, FLAW_NONE, FILL_RANDOM);
        while (sent < target_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                flaw = FLAW_NONE;
                len  = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_LEN + 1, 130) : MIN_LEN;
            end else if (pick < 75) begin
                flaw = t_flaw'($urandom_range(FLAW_CHECKSUM, FLAW_MAC));
                len  = $urandom_range(MIN_LEN, 100);
            end else if (pick < 90) begin
                flaw = FLAW_NONE;
                len  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 12)
                                                  : $urandom_range(13, MIN_LEN - 1);
            end else begin
                flaw = FLAW_NOISE;
                len  = $urandom_range(1, 120);
            end
            queue_frame(len, flaw, FILL_RANDOM);
            sent += len;
        end
    endtask

    // Hold the stimulus sequence until every queued byte went in and every verdict came out
    task automatic drain();
        while (tx_bytes.size() != 0 || i_s_axis_tvalid || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_own_mac(input logic [47:0] mac);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mac;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        own_mac_copy  = mac;
    endtask

    function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Sender: bursts of random length with random gaps
    int    burst_left = 0;
    int    gap_left   = 0;
    t_beat beat;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            restart_frame();
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                absorb_byte(i_s_axis_tdata, i_s_axis_tlast);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (tx_bytes.size() > 0) begin
                    beat = tx_bytes.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= beat.data;
                    i_s_axis_tlast  <= beat.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                                : $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready runs broken by stall runs, and the result check
    int       ready_left = 0;
    int       stall_left = 0;
    t_verdict want;
    logic     next_ready;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("accepted", want.accepted, o_m_axis_tdata[0]);
                    check_field("reject_reason", want.reason, o_m_axis_tdata[3:1]);
                    check_field("assigned_ip", want.yiaddr, o_m_axis_tdata[35:4]);
                    check_field("siaddr", want.siaddr, o_m_axis_tdata[67:36]);
                    check_field("source MAC", want.smac, o_m_axis_tdata[115:68]);
                    check_field("padding", '0, o_m_axis_tdata[119:116]);
                end
            end
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (ready_left > 0) begin
                ready_left--;
                next_ready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else begin
                ready_left = $urandom_range(0, 24);
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                next_ready = 1'b1;
            end
            i_m_axis_tready <= next_ready;
        end
    end

    // Watchdog: too long without any transaction
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // Stimulus sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // own_mac still at its reset value
        queue_frame(MIN_LEN, FLAW_NONE, FILL_RANDOM);
        queue_frame(MIN_LEN, FLAW_MAC, FILL_RANDOM);
        drain();

        write_own_mac(48'h0123_4567_89ab);
        queue_frame(MIN_LEN, FLAW_NONE, FILL_RANDOM);
        queue_frame(MIN_LEN - 1, FLAW_NONE, FILL_RANDOM);
        queue_frame(1, FLAW_NOISE, FILL_RANDOM);
        queue_frame(MIN_LEN, FLAW_CHECKSUM, FILL_RANDOM);
        queue_frame(MIN_LEN, FLAW_PROTO, FILL_RANDOM);
        queue_frame(MIN_LEN, FLAW_SRC_PORT, FILL_RANDOM);
        queue_frame(MIN_LEN, FLAW_DST_PORT, FILL_RANDOM);
        queue_frame(MIN_LEN, FLAW_OP, FILL_RANDOM);
        queue_frame(MIN_LEN, FLAW_MAC, FILL_RANDOM);
        queue_frame(MIN_LEN, FLAW_NOISE, FILL_ZERO);
        queue_frame(MIN_LEN, FLAW_NOISE, FILL_ONE);
        // all-ones header forces end-around carries in the sum
        queue_frame(MIN_LEN, FLAW_NONE, FILL_ONE);
        queue_frame(MIN_LEN + 4, FLAW_NONE, FILL_ZERO);
        drain();

        write_own_mac(48'hffff_ffff_ffff);
        random_traffic(100, 1'b1);
        drain();

        write_own_mac(48'h0000_0000_0000);
        random_traffic(100, 1'b0);
        drain();

        write_own_mac({16'($urandom), 32'($urandom)});
        random_traffic(100, 1'b0);
        drain();

        write_own_mac({16'($urandom), 32'($urandom)});
        random_traffic(100, 1'b0);
        drain();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> bootp_reply_frame_filter.f
hw/rtl/bprf_pkg.sv
hw/rtl/bootp_reply_frame_filter.sv
test/testbench.sv
